// ===== rtl/spsc_pkg.sv =====
// package for the sensor persistence and step check block
// status codes, register indexes, field widths and shared types; no dependencies
package spsc_pkg;

   localparam int NumQty          = 5;
   localparam int ValueWidth      = 16;
   localparam int TimeWidth       = 32;
   localparam int MinutesWidth    = 10;
   localparam int LimitWidth      = 15;
   localparam int CsrIndexWidth   = 3;
   localparam int CsrDataWidth    = 16;
   localparam int DefaultDepth    = 16;
   localparam int SecondsPerMinute = 60;
   localparam int WindowWidth     = 16;
   localparam int EntryWidth      = TimeWidth + NumQty * ValueWidth;

   typedef enum logic [1:0] {
      ST_NONE = 2'd0,
      ST_NA   = 2'd1,
      ST_PASS = 2'd2,
      ST_FAIL = 2'd3
   } status_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_FILL_CODE      = 3'd0,
      CSR_PERSIST_WINDOW = 3'd1,
      CSR_STEP_WINDOW    = 3'd2,
      CSR_LIMIT_AIR      = 3'd3,
      CSR_LIMIT_AIR2     = 3'd4,
      CSR_LIMIT_DEW      = 3'd5,
      CSR_LIMIT_SURFACE  = 3'd6,
      CSR_LIMIT_PRESSURE = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_WALK,
      FSM_DONE
   } fsm_state_type;

   typedef logic [ValueWidth-1:0] value_array_type [NumQty];
   typedef status_type status_array_type [NumQty];

   // per-quantity walk state
   typedef struct packed {
      logic       persist_done;
      logic       step_done;
      status_type persist_st;
      status_type step_st;
   } lane_type;

endpackage

// ===== rtl/spsc_lane.sv =====
// one quantity of the walk: persistence and step status update per older sample
// depends on spsc_pkg
module spsc_lane import spsc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  new_missing,
   input  logic                  sample_valid,
   input  logic                  persist_in_win,
   input  logic                  step_in_win,
   input  logic [ValueWidth-1:0] new_value,
   input  logic [ValueWidth-1:0] old_value,
   input  logic [ValueWidth-1:0] fill_code,
   input  logic [LimitWidth-1:0] step_limit,
   output lane_type              lane
);

   lane_type lane_ff, lane_in;
   logic signed [ValueWidth:0] diff;
   logic [ValueWidth:0]        abs_diff;
   logic                       old_missing;

   always_comb begin
      diff        = $signed({new_value[ValueWidth-1], new_value})
                  - $signed({old_value[ValueWidth-1], old_value});
      abs_diff    = diff[ValueWidth] ? (~diff + 1'b1) : diff;
      old_missing = (old_value == fill_code);
      lane_in     = lane_ff;
      if (start) begin
         lane_in.persist_done = new_missing;
         lane_in.step_done    = new_missing;
         lane_in.persist_st   = new_missing ? ST_NA : ST_PASS;
         lane_in.step_st      = new_missing ? ST_NA : ST_PASS;
      end else if (sample_valid) begin
         if (!lane_ff.persist_done) begin
            if (!persist_in_win) begin
               lane_in.persist_done = 1'b1;
            end else if (old_value == new_value) begin
               lane_in.persist_st = ST_FAIL;
            end else begin
               lane_in.persist_st   = ST_PASS;
               lane_in.persist_done = 1'b1;
            end
         end
         // missing older values are skipped before the time test
         if (!lane_ff.step_done && !old_missing) begin
            if (!step_in_win) begin
               lane_in.step_done = 1'b1;
            end else if (abs_diff > {2'b00, step_limit}) begin
               lane_in.step_st   = ST_FAIL;
               lane_in.step_done = 1'b1;
            end else begin
               lane_in.step_st = ST_PASS;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff <= '0;
      end else begin
         lane_ff <= lane_in;
      end
   end

   assign lane = lane_ff;

endmodule

// ===== rtl/sensor_persistence_and_step_check.sv =====
// top level of the sensor persistence and step check
// depends on spsc_pkg and spsc_lane
//
//  channel | direction | ports
//  req     | in        | req_valid, req_stall, check fields
//  rsp     | out       | rsp_valid, rsp_stall, ten status fields
//  csr     | in        | csr_write, csr_index, csr_data
//
// a beat is taken in idle; the walk then reads the stored_count history entries one per
// cycle, newest first, through the registered read port, then does the write-back (only
// the write-back if history is empty). the next beat is taken the cycle after the walk.
// the result sits in an output register; a new beat is taken once it is held there.
// reset clears the control state; history contents are only read once written.
// a stalled result blocks only the next item's completion.
module sensor_persistence_and_step_check import spsc_pkg::*; #(
   parameter int HISTORY_DEPTH = DefaultDepth
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_check_enable,
   input  logic [TimeWidth-1:0]     req_obs_seconds,
   input  logic [ValueWidth-1:0]    req_air_value,
   input  logic [ValueWidth-1:0]    req_air_second_value,
   input  logic [ValueWidth-1:0]    req_dew_value,
   input  logic [ValueWidth-1:0]    req_surface_value,
   input  logic [ValueWidth-1:0]    req_pressure_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_air_persist_status,
   output logic [1:0]               rsp_air_second_persist_status,
   output logic [1:0]               rsp_dew_persist_status,
   output logic [1:0]               rsp_surface_persist_status,
   output logic [1:0]               rsp_pressure_persist_status,
   output logic [1:0]               rsp_air_step_status,
   output logic [1:0]               rsp_air_second_step_status,
   output logic [1:0]               rsp_dew_step_status,
   output logic [1:0]               rsp_surface_step_status,
   output logic [1:0]               rsp_pressure_step_status,
   input  logic                     csr_write,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_data
);

   localparam int AddrWidth  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CountWidth = $clog2(HISTORY_DEPTH + 1);

   // configuration
   logic [ValueWidth-1:0]   fill_code_ff;
   logic [MinutesWidth-1:0] persist_min_ff, step_min_ff;
   logic [LimitWidth-1:0]   limit_ff [NumQty];

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_code_ff   <= 16'hD8F1;
         persist_min_ff <= MinutesWidth'(10);
         step_min_ff    <= MinutesWidth'(10);
         for (int q = 0; q < NumQty; q++) begin
            limit_ff[q] <= LimitWidth'(100);
         end
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_FILL_CODE:      fill_code_ff   <= csr_data;
            CSR_PERSIST_WINDOW: persist_min_ff <= csr_data[MinutesWidth-1:0];
            CSR_STEP_WINDOW:    step_min_ff    <= csr_data[MinutesWidth-1:0];
            CSR_LIMIT_AIR:      limit_ff[0]    <= csr_data[LimitWidth-1:0];
            CSR_LIMIT_AIR2:     limit_ff[1]    <= csr_data[LimitWidth-1:0];
            CSR_LIMIT_DEW:      limit_ff[2]    <= csr_data[LimitWidth-1:0];
            CSR_LIMIT_SURFACE:  limit_ff[3]    <= csr_data[LimitWidth-1:0];
            CSR_LIMIT_PRESSURE: limit_ff[4]    <= csr_data[LimitWidth-1:0];
            default: ;
         endcase
      end
   end

   // window lengths in seconds, registered
   logic [WindowWidth-1:0] persist_win_ff, step_win_ff;
   always_ff @(posedge clock) begin
      persist_win_ff <= WindowWidth'(persist_min_ff * SecondsPerMinute);
      step_win_ff    <= WindowWidth'(step_min_ff * SecondsPerMinute);
   end

   // control
   fsm_state_type state_ff, state_in;
   logic [AddrWidth-1:0]  write_slot_ff, write_slot_in;
   logic [CountWidth-1:0] stored_count_ff, stored_count_in;
   logic [CountWidth-1:0] issue_ff, issue_in;
   logic                  rdvalid_ff, rdvalid_in;
   logic [AddrWidth-1:0]  rdaddr_ff, rdaddr_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  enable_ff;
   logic [TimeWidth-1:0]  time_ff;
   value_array_type       val_ff;
   logic                  start;
   logic                  req_take;

   assign req_stall = (state_ff != FSM_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign start     = req_take;

   // history memory
   logic [EntryWidth-1:0] mem [HISTORY_DEPTH];
   logic [EntryWidth-1:0] rd_ff;
   logic                  mem_we;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[write_slot_ff] <= {time_ff, val_ff[0], val_ff[1], val_ff[2], val_ff[3], val_ff[4]};
      end
      rd_ff <= mem[rdaddr_ff];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: if (req_take) state_in = FSM_WALK;
         FSM_WALK: if (!rdvalid_ff && issue_ff == stored_count_ff
                       && (!rsp_valid_ff || !rsp_stall)) state_in = FSM_IDLE;
         default:  state_in = FSM_IDLE;
      endcase
   end

   logic finish;
   assign finish = (state_ff == FSM_WALK) && (state_in == FSM_IDLE);
   assign mem_we = finish;

   always_comb begin
      issue_in        = issue_ff;
      rdvalid_in      = 1'b0;
      rdaddr_in       = rdaddr_ff;
      write_slot_in   = write_slot_ff;
      stored_count_in = stored_count_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      if (start) begin
         issue_in  = '0;
         rdaddr_in = (write_slot_ff == '0) ? AddrWidth'(HISTORY_DEPTH - 1)
                                           : write_slot_ff - 1'b1;
      end else if (state_ff == FSM_WALK && issue_ff != stored_count_ff) begin
         // issue address already set, data comes back next cycle
         issue_in   = issue_ff + 1'b1;
         rdvalid_in = 1'b1;
         rdaddr_in  = (rdaddr_ff == '0) ? AddrWidth'(HISTORY_DEPTH - 1) : rdaddr_ff - 1'b1;
      end
      if (finish) begin
         rsp_valid_in  = 1'b1;
         write_slot_in = (write_slot_ff == AddrWidth'(HISTORY_DEPTH - 1)) ? '0
                                                                         : write_slot_ff + 1'b1;
         if (stored_count_ff != CountWidth'(HISTORY_DEPTH)) begin
            stored_count_in = stored_count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= FSM_IDLE;
         issue_ff        <= '0;
         rdvalid_ff      <= 1'b0;
         rdaddr_ff       <= '0;
         write_slot_ff   <= '0;
         stored_count_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         issue_ff        <= issue_in;
         rdvalid_ff      <= rdvalid_in;
         rdaddr_ff       <= rdaddr_in;
         write_slot_ff   <= write_slot_in;
         stored_count_ff <= stored_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         enable_ff <= req_check_enable && (stored_count_ff != '0);
         time_ff   <= req_obs_seconds;
         val_ff[0] <= req_air_value;
         val_ff[1] <= req_air_second_value;
         val_ff[2] <= req_dew_value;
         val_ff[3] <= req_surface_value;
         val_ff[4] <= req_pressure_value;
      end
   end

   // older sample fields
   logic [TimeWidth-1:0] old_time, age;
   logic                 p_in_win, s_in_win;
   assign old_time = rd_ff[EntryWidth-1 -: TimeWidth];
   assign age      = time_ff - old_time;
   assign p_in_win = age < {{(TimeWidth-WindowWidth){1'b0}}, persist_win_ff};
   assign s_in_win = age < {{(TimeWidth-WindowWidth){1'b0}}, step_win_ff};

   lane_type lanes [NumQty];
   genvar g;
   generate
      for (g = 0; g < NumQty; g++) begin : g_lane
         logic [ValueWidth-1:0] newv;
         assign newv = (g == 0) ? req_air_value :
                       (g == 1) ? req_air_second_value :
                       (g == 2) ? req_dew_value :
                       (g == 3) ? req_surface_value : req_pressure_value;
         spsc_lane u_lane (
            .clock          (clock),
            .reset          (reset),
            .start          (start),
            .new_missing    (newv == fill_code_ff),
            .sample_valid   (rdvalid_ff),
            .persist_in_win (p_in_win),
            .step_in_win    (s_in_win),
            .new_value      (val_ff[g]),
            .old_value      (rd_ff[EntryWidth-TimeWidth-1-g*ValueWidth -: ValueWidth]),
            .fill_code      (fill_code_ff),
            .step_limit     (limit_ff[g]),
            .lane           (lanes[g])
         );
      end
   endgenerate

   // output register
   status_array_type p_out_ff, s_out_ff;
   always_ff @(posedge clock) begin
      if (finish) begin
         for (int q = 0; q < NumQty; q++) begin
            p_out_ff[q] <= enable_ff ? lanes[q].persist_st : ST_NONE;
            s_out_ff[q] <= enable_ff ? lanes[q].step_st : ST_NONE;
         end
      end
   end

   assign rsp_valid                     = rsp_valid_ff;
   assign rsp_air_persist_status        = p_out_ff[0];
   assign rsp_air_second_persist_status = p_out_ff[1];
   assign rsp_dew_persist_status        = p_out_ff[2];
   assign rsp_surface_persist_status    = p_out_ff[3];
   assign rsp_pressure_persist_status   = p_out_ff[4];
   assign rsp_air_step_status           = s_out_ff[0];
   assign rsp_air_second_step_status    = s_out_ff[1];
   assign rsp_dew_step_status           = s_out_ff[2];
   assign rsp_surface_step_status       = s_out_ff[3];
   assign rsp_pressure_step_status      = s_out_ff[4];

endmodule

// ===== rtl/spsc_checker.sv =====
// port-level checks for the sensor persistence and step check, bound to the top level
// depends on sensor_persistence_and_step_check
module spsc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_air_persist_status,
   input logic [1:0] rsp_air_step_status
);

   // a result is held while stalled
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_air_persist_status))
      else $error("stalled result changed");

   // a beat is never taken while the previous walk runs
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("beat taken during walk");

   // a new result needs an accepted beat before it
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without beat");

   // after reset nothing is waiting
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("state left after reset");

endmodule

bind sensor_persistence_and_step_check spsc_checker u_spsc_checker (
   .clock                  (clock),
   .reset                  (reset),
   .req_valid              (req_valid),
   .req_stall              (req_stall),
   .rsp_valid              (rsp_valid),
   .rsp_stall              (rsp_stall),
   .rsp_air_persist_status (rsp_air_persist_status),
   .rsp_air_step_status    (rsp_air_step_status)
);

// ===== bench/sensor_persistence_and_step_check_tb.sv =====
// testbench for the sensor persistence and step check block
// depends on spsc_pkg and the block under test; holds its own predictor in a scoreboard class
module sensor_persistence_and_step_check_tb;
   import spsc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      bit          en;
      bit [31:0]   secs;
      bit [15:0]   val [NumQty];
   } obs_type;

   typedef struct {
      status_type pst [NumQty];
      status_type sst [NumQty];
   } verdict_type;

   class quality_board;
      obs_type     ring [DefaultDepth];
      int          slot;
      int          filled;
      bit [15:0]   fill;
      bit [9:0]    pwin;
      bit [9:0]    swin;
      bit [14:0]   limit [NumQty];
      verdict_type pending [$];
      int          errors;

      function void clear();
         slot = 0;
         filled = 0;
         fill = 16'hD8F1;
         pwin = 10;
         swin = 10;
         foreach (limit[q]) limit[q] = 100;
         pending.delete();
         errors = 0;
      endfunction

      function void write_reg(csr_index_type idx, bit [15:0] d);
         case (idx)
            CSR_FILL_CODE:      fill = d;
            CSR_PERSIST_WINDOW: pwin = d[9:0];
            CSR_STEP_WINDOW:    swin = d[9:0];
            default:            limit[int'(idx) - int'(CSR_LIMIT_AIR)] = d[14:0];
         endcase
      endfunction

      function obs_type past(int k);
         return ring[(slot + DefaultDepth - 1 - k) % DefaultDepth];
      endfunction

      function status_type persistence(obs_type s, int q);
         status_type st;
         obs_type o;
         bit [31:0] span;
         st = ST_PASS;
         if (s.val[q] == fill) return ST_NA;
         span = pwin * 32'd60;
         for (int k = 0; k < filled; k++) begin
            o = past(k);
            if (s.secs - o.secs >= span) break;
            if (o.val[q] == s.val[q]) st = ST_FAIL;
            else begin
               st = ST_PASS;
               break;
            end
         end
         return st;
      endfunction

      function status_type step(obs_type s, int q);
         status_type st;
         obs_type o;
         bit [31:0] span;
         int d;
         st = ST_PASS;
         if (s.val[q] == fill) return ST_NA;
         span = swin * 32'd60;
         for (int k = 0; k < filled; k++) begin
            o = past(k);
            if (o.val[q] == fill) continue;
            if (s.secs - o.secs >= span) break;
            d = int'($signed(s.val[q])) - int'($signed(o.val[q]));
            if (d < 0) d = -d;
            if (d > int'(limit[q])) begin
               st = ST_FAIL;
               break;
            end
            st = ST_PASS;
         end
         return st;
      endfunction

      function void note_obs(obs_type s);
         verdict_type v;
         for (int q = 0; q < NumQty; q++) begin
            v.pst[q] = ST_NONE;
            v.sst[q] = ST_NONE;
            if (s.en && filled > 0) begin
               v.pst[q] = persistence(s, q);
               v.sst[q] = step(s, q);
            end
         end
         pending.insert(pending.size(), v);
         ring[slot] = s;
         slot = (slot + 1) % DefaultDepth;
         if (filled < DefaultDepth) filled++;
      endfunction

      function void check_verdict(status_type p [NumQty], status_type s [NumQty]);
         verdict_type v;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result beat", $time);
            errors++;
            return;
         end
         v = pending.pop_front();
         for (int q = 0; q < NumQty; q++) begin
            if (p[q] !== v.pst[q]) begin
               $display("%0t: persist q%0d expected %0d actual %0d", $time, q, v.pst[q], p[q]);
               errors++;
            end
            if (s[q] !== v.sst[q]) begin
               $display("%0t: step q%0d expected %0d actual %0d", $time, q, v.sst[q], s[q]);
               errors++;
            end
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic req_check_enable = 0;
   logic [31:0] req_obs_seconds = 0;
   logic [15:0] req_val [NumQty];
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [1:0] rsp_p [NumQty];
   logic [1:0] rsp_s [NumQty];
   logic csr_write = 0;
   logic [CsrIndexWidth-1:0] csr_index = CSR_FILL_CODE;
   logic [15:0] csr_data = 0;

   quality_board board;
   int send_idle;
   int stall_pct;
   bit [31:0] clock_secs;

   initial foreach (req_val[q]) req_val[q] = 0;

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   sensor_persistence_and_step_check i_dut (
      .clock, .reset, .req_valid, .req_stall,
      .req_check_enable, .req_obs_seconds,
      .req_air_value(req_val[0]), .req_air_second_value(req_val[1]),
      .req_dew_value(req_val[2]), .req_surface_value(req_val[3]),
      .req_pressure_value(req_val[4]),
      .rsp_valid, .rsp_stall,
      .rsp_air_persist_status(rsp_p[0]), .rsp_air_second_persist_status(rsp_p[1]),
      .rsp_dew_persist_status(rsp_p[2]), .rsp_surface_persist_status(rsp_p[3]),
      .rsp_pressure_persist_status(rsp_p[4]),
      .rsp_air_step_status(rsp_s[0]), .rsp_air_second_step_status(rsp_s[1]),
      .rsp_dew_step_status(rsp_s[2]), .rsp_surface_step_status(rsp_s[3]),
      .rsp_pressure_step_status(rsp_s[4]),
      .csr_write, .csr_index, .csr_data
   );

   // result side: random stall, check each beat at the rising edge
   always @(posedge clock) begin
      status_type p [NumQty];
      status_type s [NumQty];
      if (!reset && rsp_valid && !rsp_stall) begin
         for (int q = 0; q < NumQty; q++) begin
            p[q] = status_type'(rsp_p[q]);
            s[q] = status_type'(rsp_s[q]);
         end
         board.check_verdict(p, s);
      end
   end

   always @(negedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   task automatic write_reg(csr_index_type idx, bit [15:0] d);
      @(negedge clock);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= d;
      board.write_reg(idx, d);
      @(negedge clock);
      csr_write <= 0;
   endtask

   // valid stays up after a beat until the next send or a drain replaces it
   task automatic send_obs(obs_type s);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_check_enable <= s.en;
      req_obs_seconds <= s.secs;
      foreach (req_val[q]) req_val[q] <= s.val[q];
      do @(posedge clock); while (req_stall);
      board.note_obs(s);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (25) @(negedge clock);
   endtask

   // mostly plausible sequences: small steps in time, values near the last ones
   function automatic obs_type next_obs(obs_type last, int mode);
      obs_type s;
      s.en = ($urandom_range(9) != 0);
      case ($urandom_range(9))
         0: s.secs = $urandom();
         1, 2: s.secs = last.secs;
         default: s.secs = last.secs + $urandom_range(mode ? 1200 : 120);
      endcase
      for (int q = 0; q < NumQty; q++) begin
         case ($urandom_range(9))
            0: s.val[q] = board.fill;
            1: s.val[q] = $urandom();
            2, 3, 4: s.val[q] = last.val[q];
            default: s.val[q] = last.val[q] + 16'($urandom_range(300)) - 16'd150;
         endcase
      end
      return s;
   endfunction

   task automatic random_phase(int n, int idle, int stall);
      obs_type s;
      send_idle = idle;
      stall_pct = stall;
      s = board.past(0);
      for (int i = 0; i < n; i++) begin
         s = next_obs(s, i % 2);
         send_obs(s);
      end
      send_idle = 0;
      stall_pct = 0;
      drain();
   endtask

   initial begin
      obs_type s;
      board = new();
      board.clear();
      send_idle = 0;
      stall_pct = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: empty history, checks off, missing, extremes, step just over limit
      s.en = 1; s.secs = 0;
      foreach (s.val[q]) s.val[q] = 16'h8000;
      s.val[0] = board.fill;
      send_obs(s);
      s.en = 0; s.secs = 30;
      send_obs(s);
      s.en = 1; s.secs = 60;
      send_obs(s);
      s.secs = 90;
      foreach (s.val[q]) s.val[q] = 16'h7FFF;
      s.val[1] = board.fill;
      send_obs(s);
      s.secs = 120;
      s.val[2] = 16'h7FFF - 16'd100;
      s.val[3] = 16'h7FFF - 16'd101;
      send_obs(s);
      s.secs = 599;
      send_obs(s);
      s.secs = 32'hFFFF_FFF0;
      send_obs(s);
      s.secs = 32'd5;
      send_obs(s);
      s.secs = 32'hFFFF_FFFF;
      foreach (s.val[q]) s.val[q] = 16'h0000;
      send_obs(s);
      drain();

      write_reg(CSR_PERSIST_WINDOW, 0);
      write_reg(CSR_STEP_WINDOW, 0);
      s.secs = 32'hFFFF_FFFF;
      send_obs(s);
      drain();

      random_phase(150, 0, 0);
      write_reg(CSR_FILL_CODE, 16'h8000);
      write_reg(CSR_PERSIST_WINDOW, 10'h3FF);
      write_reg(CSR_STEP_WINDOW, 10'h3FF);
      write_reg(CSR_LIMIT_AIR, 0);
      write_reg(CSR_LIMIT_AIR2, 15'h7FFF);
      write_reg(CSR_LIMIT_DEW, 50);
      write_reg(CSR_LIMIT_SURFACE, 15'h5555);
      write_reg(CSR_LIMIT_PRESSURE, 15'h2AAA);
      random_phase(150, 80, 0);
      write_reg(CSR_FILL_CODE, 16'h7FFF);
      write_reg(CSR_PERSIST_WINDOW, 1);
      write_reg(CSR_STEP_WINDOW, 5);
      random_phase(150, 0, 80);
      write_reg(CSR_FILL_CODE, 16'hD8F1);
      write_reg(CSR_PERSIST_WINDOW, 10'h155);
      write_reg(CSR_STEP_WINDOW, 10'h2AA);
      write_reg(CSR_LIMIT_AIR, 100);
      write_reg(CSR_LIMIT_DEW, 200);
      random_phase(150, 37, 37);
      write_reg(CSR_PERSIST_WINDOW, 10);
      write_reg(CSR_STEP_WINDOW, 20);
      random_phase(150, 0, 0);

      if (board.errors == 0 && board.pending.size() == 0) $display("sensor_persistence_and_step_check_tb OK");
      else $display("sensor_persistence_and_step_check_tb NOT OK");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("sensor_persistence_and_step_check_tb NOT OK");
      $finish;
   end
endmodule
